[design/psu_pkg.sv]
// Shared types and constants of the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

    localparam int BPP_W      = 4;
    localparam int ROW_W      = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'd1;

    localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
    localparam logic [ROW_W-1:0] ROW_RESET = 14'd4096;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // Everything the back end needs to rebuild one data byte, except its column.
    typedef struct packed {
        logic [7:0] data;
        filter_t    filter;
        logic       first_row;
        logic       has_left;
        logic       last;
        logic       err;
    } item_ctl_t;

endpackage

[design/psu_in_if.sv]
// Input channel: filtered bytes with the image start mark.
`timescale 1ns / 1ps

interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       image_start;

    modport source (output valid, output data_byte, output image_start, input ready);
    modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

[design/psu_out_if.sv]
// Output channel: reconstructed bytes with row end and error flag.
`timescale 1ns / 1ps

interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                    output ready);
endinterface

[design/psu_front.sv]
// Front end: tracks the scanline position, decodes filter bytes, queues data bytes.
`timescale 1ns / 1ps

module psu_front #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int IDX_W           = 13,
    parameter int CNT_W           = 14,
    parameter int TAP_W           = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    psu_in_if.sink                        filtered,
    input  logic [psu_pkg::BPP_W-1:0]     bytes_per_pixel,
    input  logic [psu_pkg::ROW_W-1:0]     row_bytes,
    input  logic                          full,
    output logic                          push,
    output logic [IDX_W-1:0]              push_idx,
    output psu_pkg::item_ctl_t            push_ctl,
    output logic [TAP_W-1:0]              left_tap
);

    localparam int LEN_W = (CNT_W > psu_pkg::ROW_W) ? CNT_W : psu_pkg::ROW_W;

    logic [CNT_W-1:0]         col_reg;
    psu_pkg::filter_t         filter_reg;
    logic                     first_reg;
    logic                     err_reg;

    logic [CNT_W-1:0]         col_eff;
    logic                     first_eff;
    logic                     err_eff;
    logic                     bad;
    logic                     is_filter;
    logic                     accept;
    logic                     last;
    logic [psu_pkg::BPP_W-1:0] bpp_eff;
    logic [LEN_W-1:0]         row_ext;
    logic [CNT_W-1:0]         len_eff;

    assign filtered.ready = !full;
    assign accept = filtered.valid && filtered.ready;

    always_comb
    begin
        if (bytes_per_pixel == '0)
            bpp_eff = psu_pkg::BPP_W'(1);
        else if (bytes_per_pixel > psu_pkg::BPP_W'(MAX_PIXEL_BYTES))
            bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
        else
            bpp_eff = bytes_per_pixel;

        row_ext = LEN_W'(row_bytes);
        if (row_bytes == '0)
            len_eff = CNT_W'(1);
        else if (row_ext > LEN_W'(MAX_ROW_BYTES))
            len_eff = CNT_W'(MAX_ROW_BYTES);
        else
            len_eff = CNT_W'(row_ext);
    end

    assign left_tap = TAP_W'(bpp_eff - psu_pkg::BPP_W'(1));

    // An image start restarts the row state before this byte is looked at.
    assign col_eff   = filtered.image_start ? '0 : col_reg;
    assign first_eff = filtered.image_start | first_reg;
    assign err_eff   = !filtered.image_start & err_reg;
    assign bad       = filtered.data_byte > 8'(psu_pkg::FILT_PAETH);
    assign is_filter = (col_eff == '0);
    assign last      = (col_eff >= len_eff);

    assign push     = accept && !is_filter;
    assign push_idx = IDX_W'(col_eff - CNT_W'(1));

    always_comb
    begin
        push_ctl.data      = filtered.data_byte;
        push_ctl.filter    = filter_reg;
        push_ctl.first_row = first_eff;
        push_ctl.has_left  = (push_idx >= IDX_W'(bpp_eff));
        push_ctl.last      = last;
        push_ctl.err       = err_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            filter_reg <= psu_pkg::FILT_NONE;
            first_reg  <= 1'b1;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (is_filter)
            begin
                filter_reg <= bad ? psu_pkg::FILT_NONE
                                  : psu_pkg::filter_t'(filtered.data_byte[2:0]);
                err_reg    <= err_eff | bad;
                col_reg    <= CNT_W'(1);
                first_reg  <= first_eff;
            end
            else
            begin
                err_reg   <= err_eff;
                first_reg <= last ? 1'b0 : first_eff;
                col_reg   <= last ? '0 : col_eff + CNT_W'(1);
            end
        end
    end

endmodule

[design/psu_queue.sv]
// Short queue between the front and back ends.
`timescale 1ns / 1ps

module psu_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[design/psu_back.sv]
// Back end: line store read, predictor, byte history and output register.
`timescale 1ns / 1ps

module psu_back #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int IDX_W           = 13,
    parameter int CNT_W           = 14,
    parameter int TAP_W           = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  logic [IDX_W-1:0]   head_idx,
    input  psu_pkg::item_ctl_t head_ctl,
    input  logic [TAP_W-1:0]   left_tap,
    output logic               pop,
    psu_out_if.source          unfiltered
);

    logic [7:0]         line_mem [MAX_ROW_BYTES];
    logic [7:0]         rd_data_reg;
    logic               above_known_reg;
    logic [CNT_W-1:0]   fill_reg;

    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    psu_pkg::item_ctl_t s1_ctl_reg;

    logic [7:0]         left_hist_reg  [MAX_PIXEL_BYTES];
    logic [7:0]         upper_hist_reg [MAX_PIXEL_BYTES];

    logic               out_valid_reg;
    logic [7:0]         pixel_reg;
    logic               row_end_reg;
    logic               bad_reg;

    logic               s1_adv;
    logic               bypass;
    logic [7:0]         above;
    logic [7:0]         left;
    logic [7:0]         corner;
    logic [8:0]         avg_sum;
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0]         pa;
    logic [9:0]         pb;
    logic [9:0]         pc;
    logic [7:0]         paeth;
    logic [7:0]         pred;
    logic [7:0]         rec;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || unfiltered.ready);
    assign pop    = head_valid && (!s1_valid_reg || s1_adv);
    // The byte written this cycle goes to the same line store entry as the byte being read.
    assign bypass = s1_adv && (s1_idx_reg == head_idx);

    // Line store: the written entries always form a prefix of the row, so
    // anything at or past the fill mark is read as zero, not its stored value.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_idx_reg] <= rec;
        if (pop)
        begin
            rd_data_reg     <= bypass ? rec : line_mem[head_idx];
            above_known_reg <= bypass || (CNT_W'(head_idx) < fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (s1_adv && (CNT_W'(s1_idx_reg) >= fill_reg))
            fill_reg <= CNT_W'(s1_idx_reg) + CNT_W'(1);
    end

    always_comb
    begin
        above  = (s1_ctl_reg.first_row || !above_known_reg) ? 8'd0 : rd_data_reg;
        left   = s1_ctl_reg.has_left ? left_hist_reg[left_tap] : 8'd0;
        corner = (s1_ctl_reg.has_left && !s1_ctl_reg.first_row)
                 ? upper_hist_reg[left_tap] : 8'd0;

        avg_sum = {1'b0, left} + {1'b0, above};

        sa = 11'(left);
        sb = 11'(above);
        sc = 11'(corner);
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = da[10] ? 10'(-da) : 10'(da);
        pb = db[10] ? 10'(-db) : 10'(db);
        pc = dc[10] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
            paeth = left;
        else if (pb <= pc)
            paeth = above;
        else
            paeth = corner;

        unique case (s1_ctl_reg.filter)
            psu_pkg::FILT_SUB:   pred = left;
            psu_pkg::FILT_UP:    pred = above;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth;
            default:             pred = 8'd0;
        endcase

        rec = s1_ctl_reg.data + pred;
    end

    // History only feeds bytes of the same row, so it needs no clearing.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_idx_reg <= head_idx;
            s1_ctl_reg <= head_ctl;
        end
        if (s1_adv)
        begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--)
            begin
                left_hist_reg[k]  <= left_hist_reg[k - 1];
                upper_hist_reg[k] <= upper_hist_reg[k - 1];
            end
            left_hist_reg[0]  <= rec;
            upper_hist_reg[0] <= above;
            pixel_reg         <= rec;
            row_end_reg       <= s1_ctl_reg.last;
            bad_reg           <= s1_ctl_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (unfiltered.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign unfiltered.valid      = out_valid_reg;
    assign unfiltered.pixel_byte = pixel_reg;
    assign unfiltered.row_end    = row_end_reg;
    assign unfiltered.bad_filter = bad_reg;

endmodule

[design/png_scanline_unfilter.sv]
// Top level of the PNG scanline unfilter.
`timescale 1ns / 1ps
// The filtered channel takes one inflated image byte per item, with image_start
// marking the first byte of an image. The first byte of each scanline is the
// filter type and gives no result; each following byte gives one item on the
// unfiltered channel with the rebuilt byte, a row end mark and the sticky
// bad-filter flag. The user must write bytes_per_pixel and row_bytes on the cfg
// port (index 0 and 1) while no item is in flight; the block never checks this.
// One byte is taken per cycle while the queue has room. A data byte is written
// into the queue, moves from its head into the stage-one registers together
// with the line store read, and the predictor result then lands in the
// output register.
// The line store port allows one read and one write per cycle, which sets
// the rate of one byte per cycle while the receiver takes every item.
// Reset restores the register defaults, empties the queue and starts in front
// of a filter byte on the first row; the line store needs no clearing pass.
// When the receiver stalls, the output register holds its item, the back end
// stops, and the four-entry queue keeps taking bytes until it fills.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psu_in_if.sink                          filtered,
    psu_out_if.source                       unfiltered,
    input  logic                            cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W   = $clog2(MAX_ROW_BYTES);
    localparam int CNT_W   = $clog2(MAX_ROW_BYTES + 1);
    localparam int TAP_W   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int ENTRY_W = IDX_W + $bits(psu_pkg::item_ctl_t);

    logic [psu_pkg::BPP_W-1:0] bpp_reg;
    logic [psu_pkg::ROW_W-1:0] row_reg;

    logic                      full;
    logic                      push;
    logic [IDX_W-1:0]          push_idx;
    psu_pkg::item_ctl_t        push_ctl;
    logic [TAP_W-1:0]          left_tap;
    logic                      pop;
    logic                      head_valid;
    logic [ENTRY_W-1:0]        head_data;
    logic [IDX_W-1:0]          head_idx;
    psu_pkg::item_ctl_t        head_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= psu_pkg::BPP_RESET;
            row_reg <= psu_pkg::ROW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psu_pkg::REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[psu_pkg::BPP_W-1:0];
                psu_pkg::REG_ROW_BYTES:       row_reg <= cfg_data[psu_pkg::ROW_W-1:0];
                default:                      ;
            endcase
        end
    end

    psu_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .IDX_W           (IDX_W),
        .CNT_W           (CNT_W),
        .TAP_W           (TAP_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .filtered        (filtered),
        .bytes_per_pixel (bpp_reg),
        .row_bytes       (row_reg),
        .full            (full),
        .push            (push),
        .push_idx        (push_idx),
        .push_ctl        (push_ctl),
        .left_tap        (left_tap)
    );

    psu_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (psu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_idx, push_ctl}),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_idx = head_data[ENTRY_W-1 -: IDX_W];
    assign head_ctl = psu_pkg::item_ctl_t'(head_data[$bits(psu_pkg::item_ctl_t)-1:0]);

    psu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .IDX_W           (IDX_W),
        .CNT_W           (CNT_W),
        .TAP_W           (TAP_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_idx   (head_idx),
        .head_ctl   (head_ctl),
        .left_tap   (left_tap),
        .pop        (pop),
        .unfiltered (unfiltered)
    );

endmodule
